[design/ufsc_pkg.sv]
// Shared types, constants and register codes of the UDP flow steering classifier.
`default_nettype none
package ufsc_pkg;

   localparam int FLOW_SLOTS       = 4;
   localparam int QUEUE_SLOTS      = 64;
   localparam int KEY_WIDTH        = 48;
   localparam int CSR_DATA_WIDTH   = 64;
   localparam int CSR_INDEX_WIDTH  = 3;
   localparam int POS_WIDTH        = 7;
   localparam int QUEUE_WIDTH      = 6;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_FLOW_KEY_A        = 3'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_FLOW_VALID_MASK   = 3'd4;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_QUEUE_SOCKET_MASK = 3'd5;

   localparam logic [1:0] VERDICT_PASS     = 2'd0;
   localparam logic [1:0] VERDICT_REDIRECT = 2'd1;
   localparam logic [1:0] VERDICT_ABORT    = 2'd2;

   localparam logic [POS_WIDTH-1:0] POS_MAX        = 7'd127;
   localparam logic [POS_WIDTH-1:0] POS_TYPE_HI    = 7'd12;
   localparam logic [POS_WIDTH-1:0] POS_TYPE_LO    = 7'd13;
   localparam logic [POS_WIDTH-1:0] POS_IHL        = 7'd14;
   localparam logic [POS_WIDTH-1:0] POS_PROTOCOL   = 7'd23;
   localparam logic [POS_WIDTH-1:0] POS_DST_ADDR   = 7'd30;
   localparam logic [POS_WIDTH-1:0] PORT_BASE      = 7'd16;
   localparam logic [POS_WIDTH-1:0] MIN_FRAME_LAST = 7'd41;

   localparam logic [23:0] UDP_IPV4_TAG = 24'h080011;

   typedef struct packed {
      logic [7:0]             frame_byte;
      logic                   frame_end;
      logic [QUEUE_WIDTH-1:0] receive_queue;
   } req_word_type;

   typedef struct packed {
      logic [POS_WIDTH-1:0]   pos;
      logic [POS_WIDTH-1:0]   port_at;
      logic [23:0]            tag;
      logic [31:0]            addr;
      logic [15:0]            port;
      logic [QUEUE_WIDTH-1:0] queue;
   } frame_view_type;

   typedef struct packed {
      logic [1:0]             verdict;
      logic [QUEUE_WIDTH-1:0] target_queue;
   } rsp_word_type;

endpackage
`default_nettype wire

[design/ufsc_intf.sv]
// Request and response channel interfaces of the classifier.
`default_nettype none
interface ufsc_req_intf;
   logic       valid;
   logic       ready;
   logic [7:0] frame_byte;
   logic       frame_end;
   logic [5:0] receive_queue;

   modport source (output valid, output frame_byte, output frame_end,
                   output receive_queue, input ready);
   modport sink (input valid, input frame_byte, input frame_end,
                 input receive_queue, output ready);
endinterface

interface ufsc_rsp_intf;
   logic       valid;
   logic       ready;
   logic [1:0] verdict;
   logic [5:0] target_queue;

   modport source (output valid, output verdict, output target_queue, input ready);
   modport sink (input valid, input verdict, input target_queue, output ready);
endinterface
`default_nettype wire

[design/ufsc_frame_parser.sv]
// Per-frame header capture: byte position, type/protocol, IHL, address and port.
`default_nettype none
module ufsc_frame_parser (
   input  wire                              clock,
   input  wire                              reset,
   input  wire                              advance,
   input  ufsc_pkg::req_word_type           word,
   output ufsc_pkg::frame_view_type         view
);

   logic [ufsc_pkg::POS_WIDTH-1:0] pos_ff, pos_in;
   logic [23:0]                    tag_ff, tag_in;
   logic [3:0]                     hw_ff, hw_in;
   logic [31:0]                    addr_ff, addr_in;
   logic [15:0]                    port_ff, port_in;
   logic [ufsc_pkg::POS_WIDTH-1:0] port_at;

   always_comb begin
      tag_in  = tag_ff;
      addr_in = addr_ff;
      port_in = port_ff;
      hw_in   = hw_ff;
      if (pos_ff == ufsc_pkg::POS_TYPE_HI) tag_in[23:16] = word.frame_byte;
      if (pos_ff == ufsc_pkg::POS_TYPE_LO) tag_in[15:8]  = word.frame_byte;
      if (pos_ff == ufsc_pkg::POS_PROTOCOL) tag_in[7:0]  = word.frame_byte;
      if (pos_ff == ufsc_pkg::POS_IHL) hw_in = word.frame_byte[3:0];
      for (int k = 0; k < 4; k++) begin
         if (pos_ff == ufsc_pkg::POS_DST_ADDR + ufsc_pkg::POS_WIDTH'(k)) begin
            addr_in[8*k +: 8] = word.frame_byte;
         end
      end
      port_at = ufsc_pkg::PORT_BASE + {1'b0, hw_in, 2'b00};
      if (pos_ff == port_at) port_in[7:0] = word.frame_byte;
      if (pos_ff == port_at + 7'd1) port_in[15:8] = word.frame_byte;
      pos_in = (pos_ff == ufsc_pkg::POS_MAX) ? pos_ff : pos_ff + 7'd1;
   end

   always_comb begin
      view.pos     = pos_ff;
      view.port_at = port_at;
      view.tag     = tag_in;
      view.addr    = addr_in;
      view.port    = port_in;
      view.queue   = word.receive_queue;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff  <= '0;
         tag_ff  <= '0;
         hw_ff   <= '0;
         addr_ff <= '0;
         port_ff <= '0;
      end else if (advance) begin
         if (word.frame_end) begin
            pos_ff  <= '0;
            tag_ff  <= '0;
            hw_ff   <= '0;
            addr_ff <= '0;
            port_ff <= '0;
         end else begin
            pos_ff  <= pos_in;
            tag_ff  <= tag_in;
            hw_ff   <= hw_in;
            addr_ff <= addr_in;
            port_ff <= port_in;
         end
      end
   end

endmodule
`default_nettype wire

[design/ufsc_flow_matcher.sv]
// Flow key table, socket mask registers and verdict decision.
`default_nettype none
module ufsc_flow_matcher #(
   parameter int KEY_ENTRIES = ufsc_pkg::FLOW_SLOTS,
   parameter int QUEUE_COUNT = ufsc_pkg::QUEUE_SLOTS
) (
   input  wire                                       clock,
   input  wire                                       reset,
   input  wire                                       csr_write_enable,
   input  wire  [ufsc_pkg::CSR_INDEX_WIDTH-1:0]      csr_index,
   input  wire  [ufsc_pkg::CSR_DATA_WIDTH-1:0]       csr_write_data,
   input  ufsc_pkg::frame_view_type                  view,
   output ufsc_pkg::rsp_word_type                    result
);

   logic [ufsc_pkg::KEY_WIDTH-1:0] listen_key_ff [KEY_ENTRIES];
   logic [ufsc_pkg::FLOW_SLOTS-1:0] valid_ff;
   logic [QUEUE_COUNT-1:0]          socket_ff;

   logic [ufsc_pkg::KEY_WIDTH-1:0] key;
   logic                           hit;
   logic                           bound;
   logic                           eligible;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < KEY_ENTRIES; i++) listen_key_ff[i] <= '0;
         valid_ff  <= '0;
         socket_ff <= '0;
      end else if (csr_write_enable) begin
         for (int i = 0; i < KEY_ENTRIES; i++) begin
            if (csr_index == ufsc_pkg::CSR_FLOW_KEY_A + ufsc_pkg::CSR_INDEX_WIDTH'(i)) begin
               listen_key_ff[i] <= csr_write_data[ufsc_pkg::KEY_WIDTH-1:0];
            end
         end
         if (csr_index == ufsc_pkg::CSR_FLOW_VALID_MASK) begin
            valid_ff <= csr_write_data[ufsc_pkg::FLOW_SLOTS-1:0];
         end
         if (csr_index == ufsc_pkg::CSR_QUEUE_SOCKET_MASK) begin
            socket_ff <= csr_write_data[QUEUE_COUNT-1:0];
         end
      end
   end

   always_comb begin
      key = {view.addr, view.port};
      hit = 1'b0;
      for (int i = 0; i < KEY_ENTRIES; i++) begin
         if (valid_ff[i] && listen_key_ff[i] == key) hit = 1'b1;
      end
      bound = 1'b0;
      for (int i = 0; i < QUEUE_COUNT; i++) begin
         if (view.queue == ufsc_pkg::QUEUE_WIDTH'(i)) bound = socket_ff[i];
      end
      eligible = (view.pos >= ufsc_pkg::MIN_FRAME_LAST)
               && (view.tag == ufsc_pkg::UDP_IPV4_TAG)
               && (view.pos > view.port_at)
               && hit;
      result.verdict      = ufsc_pkg::VERDICT_PASS;
      result.target_queue = '0;
      if (eligible) begin
         if (bound) begin
            result.verdict      = ufsc_pkg::VERDICT_REDIRECT;
            result.target_queue = view.queue;
         end else begin
            result.verdict = ufsc_pkg::VERDICT_ABORT;
         end
      end
   end

endmodule
`default_nettype wire

[design/udp_flow_steering_classifier_unit.sv]
// Top level of the UDP flow steering classifier: input register, parser, matcher, result register.
//
//   channel  dir  handshake         word
//   req_if   in   valid/ready       frame_byte, frame_end, receive_queue
//   rsp_if   out  valid/ready       verdict, target_queue
//   csr_*    in   write enable only index, 64-bit write data
//
// One byte is taken every cycle unless a stalled verdict holds the pipe.
// The rate is set by the single parse/match pass between the input and result registers.
// Reset is synchronous and clears the frame state, valid flags and CSR registers to zero.
// A stalled verdict holds the pipe only when the byte behind it is also a last byte.
`default_nettype none
module udp_flow_steering_classifier_unit #(
   parameter int KEY_ENTRIES = ufsc_pkg::FLOW_SLOTS,
   parameter int QUEUE_COUNT = ufsc_pkg::QUEUE_SLOTS
) (
   input  wire                                    clock,
   input  wire                                    reset,
   ufsc_req_intf.sink                             req_if,
   ufsc_rsp_intf.source                           rsp_if,
   input  wire                                    csr_write_enable,
   input  wire  [ufsc_pkg::CSR_INDEX_WIDTH-1:0]   csr_index,
   input  wire  [ufsc_pkg::CSR_DATA_WIDTH-1:0]    csr_write_data
);

   logic                      in_valid_ff;
   ufsc_pkg::req_word_type    in_ff;
   logic                      rsp_valid_ff;
   ufsc_pkg::rsp_word_type    rsp_ff;
   ufsc_pkg::frame_view_type  view;
   ufsc_pkg::rsp_word_type    result;
   logic                      out_free;
   logic                      advance;
   logic                      take;

   assign out_free      = !rsp_valid_ff || rsp_if.ready;
   assign advance       = in_valid_ff && (!in_ff.frame_end || out_free);
   assign req_if.ready  = !in_valid_ff || advance;
   assign take          = req_if.valid && req_if.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_if.ready) begin
         in_valid_ff <= req_if.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         in_ff.frame_byte    <= req_if.frame_byte;
         in_ff.frame_end     <= req_if.frame_end;
         in_ff.receive_queue <= req_if.receive_queue;
      end
   end

   ufsc_frame_parser u_parser (
      .clock   (clock),
      .reset   (reset),
      .advance (advance),
      .word    (in_ff),
      .view    (view)
   );

   ufsc_flow_matcher #(
      .KEY_ENTRIES (KEY_ENTRIES),
      .QUEUE_COUNT (QUEUE_COUNT)
   ) u_matcher (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .view             (view),
      .result           (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance && in_ff.frame_end) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_if.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && in_ff.frame_end) begin
         rsp_ff <= result;
      end
   end

   assign rsp_if.valid        = rsp_valid_ff;
   assign rsp_if.verdict      = rsp_ff.verdict;
   assign rsp_if.target_queue = rsp_ff.target_queue;

endmodule
`default_nettype wire
